// ===== hdl/chenc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chenc_pkg
// Shared types and constants of the canonical Huffman encoder.
// ----------------------------------------------------------------------------
package chenc_pkg;

  localparam int NUM_SYMBOLS_DEF  = 256;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int BYTE_BITS        = 8;
  localparam int Q_DEPTH          = 2;
  localparam int ITEM_LEN_W       = 6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_OVER  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // Classified item handed from the front to the back
  typedef struct packed {
    op_e                     op;
    logic [7:0]              sym;
    logic [ITEM_LEN_W-1:0]   len;
    logic                    in_range;
  } item_t;

endpackage

// ===== hdl/chenc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chenc_in_if / chenc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface chenc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] symbol;
  logic [4:0] code_length;

  modport source (output valid, output opcode, output symbol, output code_length,
                  input ready);
  modport sink   (input valid, input opcode, input symbol, input code_length,
                  output ready);
endinterface

interface chenc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [31:0] total_bits;
  logic        last;

  modport source (output valid, output kind, output out_byte, output status,
                  output total_bits, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input status,
                  input total_bits, input last, output ready);
endinterface

// ===== hdl/chenc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chenc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chenc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/chenc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chenc_front
// Accept input items, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
module chenc_front import chenc_pkg::*; #(
  parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        busy_i,
  chenc_in_if.sink    in_i,
  output item_t       item_o,
  output logic        item_valid_o,
  input  logic        item_ready_i
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  item_t          q_mem_q [Q_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  item_t          cls;
  logic           push, pop;

  // Classify: range check and length saturation
  always_comb begin
    cls.op       = op_e'(in_i.opcode);
    cls.sym      = in_i.symbol;
    cls.in_range = (32'(in_i.symbol) < 32'(NUM_SYMBOLS));
    if (ITEM_LEN_W'(in_i.code_length) > ITEM_LEN_W'(MAX_CODE_LEN)) begin
      cls.len = ITEM_LEN_W'(MAX_CODE_LEN);
    end else begin
      cls.len = ITEM_LEN_W'(in_i.code_length);
    end
  end

  assign in_i.ready   = (cnt_q != CW'(Q_DEPTH)) && !busy_i;
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem_q[rd_ptr_q];
  assign pop          = item_valid_o && item_ready_i;

  // Advance queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) wr_ptr_d = (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store classified item
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== hdl/chenc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chenc_back
// Execute queued items: table loads, canonical code build, bit packing.
// ----------------------------------------------------------------------------
module chenc_back import chenc_pkg::*; #(
  parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  output logic        busy_o,
  chenc_out_if.source out_o
);

  localparam int AW    = $clog2(NUM_SYMBOLS);
  localparam int LW    = $clog2(MAX_CODE_LEN + 1);
  localparam int CW    = MAX_CODE_LEN;
  localparam int CNTW  = AW + 1;
  localparam int CODEW = MAX_CODE_LEN + AW + 2;
  localparam int ACCW  = MAX_CODE_LEN + 7;
  localparam int NW    = $clog2(ACCW + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SYMBOLS - 1);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_LOOKUP  = 10'b0000000100,
    S_EMIT    = 10'b0000001000,
    S_CNT     = 10'b0000010000,
    S_CNT_END = 10'b0000100000,
    S_NEXT    = 10'b0001000000,
    S_ASG     = 10'b0010000000,
    S_ASG_END = 10'b0100000000,
    S_RESP    = 10'b1000000000
  } state_e;

  function automatic logic [CW-1:0] mask_of(input logic [LW-1:0] l);
    mask_of = ~({CW{1'b1}} << l);
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       idx_q, idx_d, p_idx_q, p_idx_d;
  logic                p_vld_q, p_vld_d;
  logic                used_q, used_d, over_q, over_d, rng_q, rng_d;
  logic [LW-1:0]       b_q, b_d;
  logic [CODEW-1:0]    code_q, code_d, code_nx;
  logic [CNTW-1:0]     cnt_q [MAX_CODE_LEN+1];
  logic [CNTW-1:0]     cnt_d [MAX_CODE_LEN+1];
  logic [CW-1:0]       nxt_q [MAX_CODE_LEN+1];
  logic [CW-1:0]       nxt_d [MAX_CODE_LEN+1];
  logic [6:0]          pend_q, pend_d;
  logic [2:0]          pc_q, pc_d;
  logic [31:0]         bt_q, bt_d;
  logic [32:0]         bt_sum;
  logic [ACCW-1:0]     acc_q, acc_d;
  logic [NW-1:0]       n_q, n_d, nrem;
  logic                res_kind_q, res_kind_d;
  logic [7:0]          res_byte_q, res_byte_d;
  logic [1:0]          res_status_q, res_status_d;
  logic [14:0]         flush_sh;
  logic [LW-1:0]       l;
  logic [CW-1:0]       codev;

  // Output register
  logic                out_vld_q, out_free, out_load;
  logic                o_kind, o_last;
  logic [7:0]          o_byte;
  logic [1:0]          o_status;
  logic                o_kind_q, o_last_q;
  logic [7:0]          o_byte_q;
  logic [1:0]          o_status_q;
  logic [31:0]         o_bits_q;

  // Memory ports
  logic                len_we, code_we;
  logic [AW-1:0]       len_waddr, len_raddr, code_waddr, code_raddr;
  logic [LW-1:0]       len_wdata, len_rdata;
  logic [LW+CW-1:0]    code_wdata, code_rdata;

  chenc_ram #(.WIDTH(LW), .DEPTH(NUM_SYMBOLS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  chenc_ram #(.WIDTH(LW + CW), .DEPTH(NUM_SYMBOLS)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (code_waddr),
    .wdata_i (code_wdata),
    .raddr_i (code_raddr),
    .rdata_o (code_rdata)
  );

  assign out_free = !out_vld_q || out_o.ready;
  assign busy_o   = (state_q == S_CLEAR);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    p_idx_d      = idx_q;
    p_vld_d      = 1'b0;
    used_d       = used_q;
    over_d       = over_q;
    rng_d        = rng_q;
    b_d          = b_q;
    code_d       = code_q;
    cnt_d        = cnt_q;
    nxt_d        = nxt_q;
    pend_d       = pend_q;
    pc_d         = pc_q;
    bt_d         = bt_q;
    acc_d        = acc_q;
    n_d          = n_q;
    res_kind_d   = res_kind_q;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    len_we       = 1'b0;
    len_waddr    = idx_q;
    len_wdata    = '0;
    len_raddr    = idx_q;
    code_we      = 1'b0;
    code_waddr   = idx_q;
    code_wdata   = '0;
    code_raddr   = AW'(item_i.sym);
    item_ready_o = 1'b0;
    out_load     = 1'b0;
    o_kind       = KIND_STATUS;
    o_byte       = '0;
    o_status     = STATUS_OK;
    o_last       = 1'b1;
    code_nx      = '0;
    bt_sum       = '0;
    flush_sh     = '0;
    nrem         = '0;
    l            = '0;
    codev        = '0;

    // Consume length read returned from the sweep
    if (p_vld_q) begin
      if (state_q == S_CNT || state_q == S_CNT_END) begin
        if (len_rdata != '0) begin
          cnt_d[len_rdata] = cnt_q[len_rdata] + 1'b1;
          used_d           = 1'b1;
        end
      end else begin
        code_we    = 1'b1;
        code_waddr = p_idx_q;
        code_wdata = {len_rdata, nxt_q[len_rdata] & mask_of(len_rdata)};
        if (len_rdata != '0) begin
          nxt_d[len_rdata] = nxt_q[len_rdata] + 1'b1;
        end
      end
    end

    unique case (state_q)
      S_CLEAR: begin
        len_we  = 1'b1;
        code_we = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          res_kind_d   = KIND_STATUS;
          res_byte_d   = '0;
          res_status_d = STATUS_OK;
          unique case (item_i.op)
            OP_LOAD: begin
              len_we    = item_i.in_range;
              len_waddr = AW'(item_i.sym);
              len_wdata = LW'(item_i.len);
              state_d   = S_RESP;
            end
            OP_BUILD: begin
              for (int i = 0; i <= MAX_CODE_LEN; i++) cnt_d[i] = '0;
              used_d  = 1'b0;
              over_d  = 1'b0;
              idx_d   = '0;
              state_d = S_CNT;
            end
            OP_ENCODE: begin
              rng_d   = item_i.in_range;
              state_d = S_LOOKUP;
            end
            OP_FLUSH: begin
              if (pc_q != '0) begin
                flush_sh   = 15'(pend_q) << (4'(BYTE_BITS) - 4'(pc_q));
                res_kind_d = KIND_BYTE;
                res_byte_d = flush_sh[7:0];
              end
              pend_d  = '0;
              pc_d    = '0;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_CNT: begin
        p_vld_d = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_CNT_END;
        end
      end
      S_CNT_END: begin
        b_d      = LW'(1);
        code_d   = '0;
        nxt_d[0] = '0;
        state_d  = S_NEXT;
      end
      S_NEXT: begin
        // First code of length b and oversubscription check
        code_nx  = (code_q + CODEW'(cnt_q[LW'(b_q - 1'b1)])) << 1;
        code_d   = code_nx;
        nxt_d[b_q] = code_nx[CW-1:0];
        if (cnt_q[b_q] != '0 &&
            (code_nx + CODEW'(cnt_q[b_q])) > (CODEW'(1) << b_q)) begin
          over_d = 1'b1;
        end
        if (b_q == LW'(MAX_CODE_LEN)) begin
          idx_d   = '0;
          state_d = S_ASG;
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      S_ASG: begin
        p_vld_d = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = S_ASG_END;
        end
      end
      S_ASG_END: begin
        res_status_d = !used_q ? STATUS_EMPTY : (over_q ? STATUS_OVER : STATUS_OK);
        state_d      = S_RESP;
      end
      S_LOOKUP: begin
        // Append the code to the partial byte
        l     = rng_q ? code_rdata[CW +: LW] : '0;
        codev = code_rdata[CW-1:0] & mask_of(l);
        acc_d = (ACCW'(pend_q) << l) | ACCW'(codev);
        n_d   = NW'(pc_q) + NW'(l);
        bt_sum = {1'b0, bt_q} + 33'(l);
        bt_d   = bt_sum[32] ? '1 : bt_sum[31:0];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (n_q < NW'(BYTE_BITS)) begin
            pend_d  = acc_q[6:0] & ~(7'h7f << n_q[2:0]);
            pc_d    = n_q[2:0];
            state_d = S_IDLE;
          end else begin
            nrem   = n_q - NW'(BYTE_BITS);
            n_d    = nrem;
            o_kind = KIND_BYTE;
            o_byte = 8'(acc_q >> nrem);
            o_last = (nrem < NW'(BYTE_BITS));
            if (o_last) begin
              pend_d  = acc_q[6:0] & ~(7'h7f << nrem[2:0]);
              pc_d    = nrem[2:0];
              state_d = S_IDLE;
            end
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          o_kind   = res_kind_q;
          o_byte   = res_byte_q;
          o_status = res_status_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      p_vld_q   <= 1'b0;
      pend_q    <= '0;
      pc_q      <= '0;
      bt_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      p_vld_q   <= p_vld_d;
      pend_q    <= pend_d;
      pc_q      <= pc_d;
      bt_q      <= bt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    p_idx_q      <= p_idx_d;
    used_q       <= used_d;
    over_q       <= over_d;
    rng_q        <= rng_d;
    b_q          <= b_d;
    code_q       <= code_d;
    cnt_q        <= cnt_d;
    nxt_q        <= nxt_d;
    acc_q        <= acc_d;
    n_q          <= n_d;
    res_kind_q   <= res_kind_d;
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      o_kind_q   <= o_kind;
      o_byte_q   <= o_byte;
      o_status_q <= o_status;
      o_last_q   <= o_last;
      o_bits_q   <= bt_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = o_kind_q;
  assign out_o.out_byte   = o_byte_q;
  assign out_o.status     = o_status_q;
  assign out_o.total_bits = o_bits_q;
  assign out_o.last       = o_last_q;

endmodule

// ===== hdl/canonical_huffman_encoder.sv =====
`timescale 1ns / 1ps
// The back end executes one item at a time: a build makes two table sweeps, and an
// encode result may be followed by a second byte.
// Reset: control state clears at once; a clearing pass then zeroes both tables while
// input transfers are held off.
// ----------------------------------------------------------------------------
// canonical_huffman_encoder
// Canonical Huffman encoder with MSB-first byte packing.
// ----------------------------------------------------------------------------
module canonical_huffman_encoder import chenc_pkg::*; #(
  parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chenc_in_if.sink    in_i,
  chenc_out_if.source out_o
);

  item_t item;
  logic  item_valid, item_ready, busy;

  // Front end: accept and classify
  chenc_front #(.NUM_SYMBOLS(NUM_SYMBOLS), .MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .busy_i       (busy),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // Back end: execute
  chenc_back #(.NUM_SYMBOLS(NUM_SYMBOLS), .MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .busy_o       (busy),
    .out_o        (out_o)
  );

`ifndef SYNTH
  // Status-only results always close their item
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind == KIND_STATUS |-> out_o.last)
    else $error("status result without last");

  // Nonzero status only on a status-only result
  a_status_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != STATUS_OK |-> out_o.kind == KIND_STATUS)
    else $error("build status on a byte result");

  // A non-final byte is followed at once by another byte
  a_byte_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last |=>
      out_o.valid && out_o.kind == KIND_BYTE)
    else $error("byte run broken");
`endif

endmodule
